/* rtl/core/srwa_pkg.sv */
// Shared constants, types and state encoding of the sample ring window average block.
package srwa_pkg;

    localparam int DEPTH    = 256;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int HELD_W   = $clog2(DEPTH + 1);

    localparam int RAW_W    = 14;
    localparam int WIN_W    = 9;
    localparam int AVG_W    = 8;
    localparam int CMP_W    = (HELD_W > WIN_W) ? HELD_W : WIN_W;
    localparam int SUM_W    = AVG_W + WIN_W;
    localparam int DCNT_W   = $clog2(SUM_W + 1);

    localparam int RAW_OFFSET = 3960;
    localparam int RECIP      = 5243;
    localparam int RECIP_W    = 13;
    localparam int RECIP_SH   = 19;
    localparam int PROD_W     = RAW_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_READ,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [WIN_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SUM_W-1:0]   quotient;
    } t_div_rsp;

endpackage

/* rtl/core/sample_ring_window_average_core.sv */
// Top level: sample ring in RAM with windowed average over the newest samples.
//
// Input channel (i_valid / o_ready) carries one item per handshake. With
// i_mode low the item is a raw 14-bit temperature code: it is converted to
// whole degrees, (raw - 3960) / 100 truncated toward zero, and written to
// the next ring slot. It gives no result.
// With i_mode high the item asks for the mean of the newest i_window_count
// samples. The ring is read one entry per cycle from the single RAM read
// port, summed, then divided by the count actually used in a bit-serial
// divider. An empty store returns zero with o_store_empty set; a zero
// window returns zero with o_samples_used zero. Both skip the read and
// divide steps. Output channel (o_valid / i_ready) is a registered stage:
// while a result waits the block keeps taking samples and finishing a
// further request up to the point of delivery. Reset clears the write
// pointer and wrap flag, making the store empty; RAM contents are not
// cleared and are never read before written.
module sample_ring_window_average_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [srwa_pkg::RAW_W-1:0]  i_raw_reading,
    input  logic [srwa_pkg::WIN_W-1:0]  i_window_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [srwa_pkg::AVG_W-1:0] o_average_degrees,
    output logic [srwa_pkg::WIN_W-1:0]  o_samples_used,
    output logic                        o_store_empty
);

    srwa_pkg::t_state r_state, n_state;

    logic [srwa_pkg::PTR_W-1:0]   r_wptr;
    logic                         r_wrapped;
    logic [srwa_pkg::RAW_W-1:0]   r_raw;
    logic [srwa_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [srwa_pkg::WIN_W-1:0]   r_left;
    logic [srwa_pkg::WIN_W-1:0]   r_used;
    logic                         r_empty;
    logic signed [srwa_pkg::SUM_W-1:0] r_sum;
    logic                         r_rd_vld;
    logic                         r_out_valid;
    logic [srwa_pkg::AVG_W-1:0]   r_out_avg;
    logic [srwa_pkg::WIN_W-1:0]   r_out_used;
    logic                         r_out_empty;

    logic                         accept;
    logic                         ram_we;
    logic                         ram_re;
    logic [srwa_pkg::AVG_W-1:0]   ram_rdata;
    logic                         out_free;
    logic                         out_load;
    logic                         div_start;
    srwa_pkg::t_div_req           div_req;
    srwa_pkg::t_div_rsp           div_rsp;

    logic [srwa_pkg::CMP_W-1:0]   held_c;
    logic [srwa_pkg::CMP_W-1:0]   want_c;
    logic [srwa_pkg::WIN_W-1:0]   used_c;

    logic                         conv_neg;
    logic [srwa_pkg::RAW_W-1:0]   conv_mag;
    logic [srwa_pkg::PROD_W-1:0]  conv_prod;
    logic [srwa_pkg::AVG_W-1:0]   conv_q;
    logic [srwa_pkg::AVG_W-1:0]   conv_deg;

    logic [srwa_pkg::AVG_W-1:0]   quo8;
    logic [srwa_pkg::AVG_W-1:0]   avg_c;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign out_load = (r_state == srwa_pkg::ST_DONE) && out_free;

    // held sample count and clipped window
    assign held_c = r_wrapped ? srwa_pkg::CMP_W'(srwa_pkg::DEPTH)
                              : srwa_pkg::CMP_W'(r_wptr);
    assign want_c = srwa_pkg::CMP_W'(i_window_count);
    assign used_c = (want_c < held_c) ? i_window_count
                                      : srwa_pkg::WIN_W'(held_c);

    // raw code to whole degrees
    assign conv_neg  = (r_raw < srwa_pkg::RAW_W'(srwa_pkg::RAW_OFFSET));
    assign conv_mag  = conv_neg ? srwa_pkg::RAW_W'(srwa_pkg::RAW_OFFSET) - r_raw
                                : r_raw - srwa_pkg::RAW_W'(srwa_pkg::RAW_OFFSET);
    assign conv_prod = srwa_pkg::PROD_W'(conv_mag)
                     * srwa_pkg::PROD_W'(srwa_pkg::RECIP);
    assign conv_q    = conv_prod[srwa_pkg::RECIP_SH +: srwa_pkg::AVG_W];
    assign conv_deg  = conv_neg ? (~conv_q + 1'b1) : conv_q;

    // signed quotient
    assign quo8  = div_rsp.quotient[srwa_pkg::AVG_W-1:0];
    assign avg_c = (r_used == '0) ? '0
                 : (r_sum[srwa_pkg::SUM_W-1] ? (~quo8 + 1'b1) : quo8);

    assign div_req.start    = div_start;
    assign div_req.dividend = r_sum[srwa_pkg::SUM_W-1]
                            ? srwa_pkg::SUM_W'(-r_sum) : srwa_pkg::SUM_W'(r_sum);
    assign div_req.divisor  = r_used;

    srwa_ram #(
        .WIDTH (srwa_pkg::AVG_W),
        .DEPTH (srwa_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (conv_deg),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    srwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            srwa_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_state = srwa_pkg::ST_STORE;
                    end else if (used_c == '0) begin
                        n_state = srwa_pkg::ST_DONE;
                    end else begin
                        n_state = srwa_pkg::ST_READ;
                    end
                end
            end
            srwa_pkg::ST_STORE: begin
                n_state = srwa_pkg::ST_IDLE;
            end
            srwa_pkg::ST_READ: begin
                if (r_left == '0 && !r_rd_vld) begin
                    n_state = srwa_pkg::ST_DIV_GO;
                end
            end
            srwa_pkg::ST_DIV_GO: begin
                n_state = srwa_pkg::ST_DIV_WAIT;
            end
            srwa_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = srwa_pkg::ST_DONE;
                end
            end
            srwa_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = srwa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srwa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        case (r_state)
            srwa_pkg::ST_IDLE:   o_ready   = 1'b1;
            srwa_pkg::ST_STORE:  ram_we    = 1'b1;
            srwa_pkg::ST_READ:   ram_re    = (r_left != '0);
            srwa_pkg::ST_DIV_GO: div_start = 1'b1;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srwa_pkg::ST_IDLE;
            r_wptr      <= '0;
            r_wrapped   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= ram_re;
            if (ram_we) begin
                if (r_wptr == srwa_pkg::PTR_W'(srwa_pkg::DEPTH - 1)) begin
                    r_wptr    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end
            if (accept && i_mode) begin
                r_left <= used_c;
            end else if (ram_re) begin
                r_left <= r_left - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw    <= i_raw_reading;
            r_used   <= used_c;
            r_empty  <= (held_c == '0);
            r_sum    <= '0;
            r_rd_ptr <= (r_wptr == '0) ? srwa_pkg::PTR_W'(srwa_pkg::DEPTH - 1)
                                       : r_wptr - 1'b1;
        end else begin
            if (ram_re) begin
                r_rd_ptr <= (r_rd_ptr == '0) ? srwa_pkg::PTR_W'(srwa_pkg::DEPTH - 1)
                                             : r_rd_ptr - 1'b1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + srwa_pkg::SUM_W'(signed'(ram_rdata));
            end
        end
        if (out_load) begin
            r_out_avg   <= avg_c;
            r_out_used  <= r_used;
            r_out_empty <= r_empty;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_average_degrees = signed'(r_out_avg);
    assign o_samples_used    = r_out_used;
    assign o_store_empty     = r_out_empty;

endmodule

/* rtl/core/srwa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module srwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/srwa_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module srwa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srwa_pkg::t_div_req i_req,
    output srwa_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [srwa_pkg::DCNT_W-1:0]  r_cnt;
    logic [srwa_pkg::SUM_W-1:0]   r_quo;
    logic [srwa_pkg::WIN_W-1:0]   r_rem;
    logic [srwa_pkg::WIN_W-1:0]   r_dsr;
    logic [srwa_pkg::WIN_W:0]     trial;
    logic                         fits;

    assign trial = {r_rem, r_quo[srwa_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= srwa_pkg::DCNT_W'(srwa_pkg::SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == srwa_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[srwa_pkg::SUM_W-2:0], fits};
            if (fits) begin
                r_rem <= srwa_pkg::WIN_W'(trial - {1'b0, r_dsr});
            end else begin
                r_rem <= trial[srwa_pkg::WIN_W-1:0];
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/core/srwa_chk.sv */
// Port-level checker for the sample ring window average block, with its bind.
module srwa_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic signed [srwa_pkg::AVG_W-1:0] o_average_degrees,
    input  logic [srwa_pkg::WIN_W-1:0]  o_samples_used,
    input  logic                        o_store_empty
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average_degrees)
            && $stable(o_samples_used) && $stable(o_store_empty))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_store_empty |-> o_samples_used == '0 && o_average_degrees == '0)
        else $error("empty store gave nonzero result");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_samples_used == '0 |-> o_average_degrees == '0)
        else $error("nonzero average with no samples");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_average_degrees >= -8'sd39 && o_average_degrees <= 8'sd124)
        else $error("average out of range");

endmodule

bind sample_ring_window_average_core srwa_chk u_srwa_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_average_degrees (o_average_degrees),
    .o_samples_used    (o_samples_used),
    .o_store_empty     (o_store_empty)
);
